>>> design/eight_bit_timer_counter_assert.svh
// Assertion macros for the eight-bit timer/counter.
`ifndef EIGHT_BIT_TIMER_COUNTER_ASSERT_SVH
`define EIGHT_BIT_TIMER_COUNTER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define EBTC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition seen at one edge is followed by another at the next edge.
`define EBTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ebtc_pkg.sv
// Types, codes and helpers shared by the eight-bit timer/counter.
`default_nettype none
package ebtc_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_CLK_SEL = 3'd1,
    REG_COUNT   = 3'd2,
    REG_COMPARE = 3'd3,
    REG_IRQ_EN  = 3'd4,
    REG_FLAGS   = 3'd5,
    REG_RSVD6   = 3'd6,
    REG_RSVD7   = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_CTC = 2'd2;
  localparam int         FLAG_OVF = 0;
  localparam int         FLAG_CMP = 1;
  localparam int         PSC_W    = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic       overflow_irq;
    logic       compare_irq;
  } res_t;

  // Prescaler divisor for a clock select; zero means stopped.
  function automatic logic [PSC_W:0] divisor_of(input logic [2:0] sel);
    logic [PSC_W:0] d;
    case (sel)
      3'd1:    d = (PSC_W+1)'(1);
      3'd2:    d = (PSC_W+1)'(8);
      3'd3:    d = (PSC_W+1)'(64);
      3'd4:    d = (PSC_W+1)'(256);
      3'd5:    d = (PSC_W+1)'(1024);
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

>>> design/eight_bit_timer_counter.sv
// Eight-bit timer/counter with prescaler, normal and CTC modes.
// An accepted result is registered in the output entry, or the skid entry on a stall.
// Throughput: one item per cycle; an output register plus one skid entry keep input
// ready while a result waits, so a stalled output blocks input only once both are full.
// Reset (synchronous, rst_n low) clears all timer registers and the prescaler, and
// empties both output entries (their data registers are not reset).
`default_nettype none
module eight_bit_timer_counter
  import ebtc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [2:0] in_reg_index,
  input  wire logic [7:0] in_write_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_read_data,
  output logic            out_overflow_irq,
  output logic            out_compare_irq
);

  `include "eight_bit_timer_counter_assert.svh"

  logic [1:0]       mode_r,   mode_nxt;
  logic [2:0]       sel_r,    sel_nxt;
  logic [7:0]       count_r,  count_nxt;
  logic [7:0]       cmp_r,    cmp_nxt;
  logic [1:0]       irq_en_r, irq_en_nxt;
  logic [1:0]       flags_r,  flags_nxt;
  logic [PSC_W-1:0] psc_r,    psc_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  res_t             out_r, out_nxt;
  res_t             skid_r, skid_nxt;

  logic             accept;
  req_t             req;
  reg_idx_t         idx;
  logic [PSC_W:0]   div;
  logic [PSC_W:0]   psc_inc;
  logic             running;
  logic             step;
  logic             ctc_clear;
  logic [7:0]       count_stepped;
  logic [7:0]       rd;
  res_t             res;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign req      = req_t'(in_req_type);
  assign idx      = reg_idx_t'(in_reg_index);

  // Prescaler and count step
  assign div           = divisor_of(sel_r);
  assign running       = (div != '0);
  assign psc_inc       = {1'b0, psc_r} + (PSC_W+1)'(1);
  assign step          = running && (psc_inc >= div);
  assign ctc_clear     = (mode_r == MODE_CTC) && (count_r == cmp_r);
  assign count_stepped = ctc_clear ? 8'd0 : count_r + 8'd1;

  always_comb begin
    mode_nxt   = mode_r;
    sel_nxt    = sel_r;
    count_nxt  = count_r;
    cmp_nxt    = cmp_r;
    irq_en_nxt = irq_en_r;
    flags_nxt  = flags_r;
    psc_nxt    = psc_r;
    rd         = 8'd0;
    if (accept) begin
      case (req)
        REQ_TICK: begin
          if (step) begin
            psc_nxt   = '0;
            count_nxt = count_stepped;
            if ((count_r == 8'hFF) && (count_stepped == 8'd0)) begin
              flags_nxt[FLAG_OVF] = 1'b1;
            end
            if (count_stepped == cmp_r) begin
              flags_nxt[FLAG_CMP] = 1'b1;
            end
          end else if (running) begin
            psc_nxt = psc_inc[PSC_W-1:0];
          end
        end
        REQ_READ: begin
          case (idx)
            REG_MODE:    rd = {6'd0, mode_r};
            REG_CLK_SEL: rd = {5'd0, sel_r};
            REG_COUNT:   rd = count_r;
            REG_COMPARE: rd = cmp_r;
            REG_IRQ_EN:  rd = {6'd0, irq_en_r};
            REG_FLAGS:   rd = {6'd0, flags_r};
            default:     rd = 8'd0;
          endcase
        end
        REQ_WRITE: begin
          case (idx)
            REG_MODE:    mode_nxt   = in_write_data[1:0];
            REG_CLK_SEL: sel_nxt    = in_write_data[2:0];
            REG_COUNT:   count_nxt  = in_write_data;
            REG_COMPARE: cmp_nxt    = in_write_data;
            REG_IRQ_EN:  irq_en_nxt = in_write_data[1:0];
            // write 1 to clear
            REG_FLAGS:   flags_nxt  = flags_r & ~in_write_data[1:0];
            default:     ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.read_data    = rd;
    res.overflow_irq = flags_nxt[FLAG_OVF] & irq_en_nxt[FLAG_OVF];
    res.compare_irq  = flags_nxt[FLAG_CMP] & irq_en_nxt[FLAG_CMP];
  end

  // Output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_nxt = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r) begin
      if (accept) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end else if (accept) begin
      // hold the waiting result, park the new one
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= '0;
      sel_r        <= '0;
      count_r      <= '0;
      cmp_r        <= '0;
      irq_en_r     <= '0;
      flags_r      <= '0;
      psc_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      sel_r        <= sel_nxt;
      count_r      <= count_nxt;
      cmp_r        <= cmp_nxt;
      irq_en_r     <= irq_en_nxt;
      flags_r      <= flags_nxt;
      psc_r        <= psc_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_r.read_data;
  assign out_overflow_irq = out_r.overflow_irq;
  assign out_compare_irq  = out_r.compare_irq;

  `EBTC_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid full with output empty")
  `EBTC_ASSERT_NEXT(a_stopped_psc_holds, accept && (req == REQ_TICK) && !running,
    $stable(psc_r), "prescaler moved while stopped")
  `EBTC_ASSERT_NEXT(a_ctc_clear, accept && (req == REQ_TICK) && step && ctc_clear,
    count_r == 8'd0, "CTC match did not clear count")
  `EBTC_ASSERT_NEXT(a_flag_clear,
    accept && (req == REQ_WRITE) && (idx == REG_FLAGS) && in_write_data[FLAG_OVF],
    !flags_r[FLAG_OVF], "overflow flag not cleared by write")

endmodule
`default_nettype wire
